### design/dll_pkg.sv
// ---------------------------------------------------------------------------
// dll_pkg: shared types for the doubly linked list engine
// Operation and status codes, controller states, and the command and status
// groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

	localparam int CAP_DEFAULT = 64;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_SEARCH     = 3'd2,
		OP_INS_AFTER  = 3'd3,
		OP_INS_BEFORE = 3'd4,
		OP_POP_FRONT  = 3'd5,
		OP_POP_BACK   = 3'd6,
		OP_DELETE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		RS_DONE      = 2'd0,
		RS_EMPTY     = 2'd1,
		RS_NOT_FOUND = 2'd2,
		RS_FULL      = 2'd3
	} rstat_t;

	typedef enum logic [1:0] {
		RA_HEAD = 2'd0,
		RA_TAIL = 2'd1,
		RA_NEXT = 2'd2
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_CAPT,
		S_WALK,
		S_DROP,
		S_TAKE,
		S_LINK1,
		S_LINK2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic    load;
		logic    fs_init;
		logic    node_rd;
		rd_sel_t rd_sel;
		logic    walk_init;
		logic    walk_adv;
		logic    capture;
		logic    push_setup;
		logic    alloc_rd;
		logic    take;
		logic    link1;
		logic    link2;
		logic    drop;
		logic    set_status;
		rstat_t  status;
		logic    set_found;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic full;
		logic empty;
		op_t  op;
		logic match;
		logic walk_end;
		logic out_free;
		logic head_nil;
		logic tail_nil;
	} sts_t;

endpackage

`default_nettype wire

### design/dll_datapath.sv
// ---------------------------------------------------------------------------
// dll_datapath: node store, free stack and result register
// Holds the node memories, head and tail, the walk pointer and the output
// register, and carries out the commands of the controller.
// ---------------------------------------------------------------------------
`default_nettype none

module dll_datapath import dll_pkg::*; #(
	parameter int CAPACITY = CAP_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [2:0]  in_op,
	input  wire logic [31:0] in_key,
	input  wire logic [31:0] in_value,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [1:0]       out_status,
	output logic             out_found,
	output logic             out_rem_valid,
	output logic [31:0]      out_rem_value
);

	localparam int NW = $clog2(CAPACITY);
	localparam int IW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	logic [31:0]   val_mem [CAPACITY];
	logic [IW-1:0] nxt_mem [CAPACITY];
	logic [IW-1:0] prv_mem [CAPACITY];
	logic [NW-1:0] fs_mem  [CAPACITY];

	logic [31:0]   rd_val_q;
	logic [IW-1:0] rd_nxt_q, rd_prv_q;
	logic [NW-1:0] fs_rd_q;

	logic [2:0]    op_q;
	logic [31:0]   key_q, val_q, cap_val_q, rem_val_q;
	logic [IW-1:0] cur_q, steps_q, m_q, p_q, n_q, ix_q;
	logic [IW-1:0] head_q, tail_q, free_top_q, init_cnt_q;
	logic [1:0]    res_stat_q;
	logic          res_found_q, rem_v_q;

	logic [IW-1:0] sel_ix, ftm1;
	logic          after, m_ok, p_ok, n_ok;

	logic          val_we, nxt_we, prv_we, fs_we;
	logic [NW-1:0] val_wa, nxt_wa, prv_wa, fs_wa, fs_wd;
	logic [31:0]   val_wd;
	logic [IW-1:0] nxt_wd, prv_wd;

	assign after = (op_q == OP_PUSH_BACK) || (op_q == OP_INS_AFTER);
	assign m_ok  = m_q < NIL;
	assign p_ok  = p_q < NIL;
	assign n_ok  = n_q < NIL;
	assign ftm1  = free_top_q - IW'(1);

	always_comb begin
		case (cmd.rd_sel)
			RA_HEAD: sel_ix = head_q;
			RA_TAIL: sel_ix = tail_q;
			default: sel_ix = rd_nxt_q;
		endcase
	end

	// Write ports of the four memories.
	always_comb begin
		val_we = cmd.take;
		val_wa = fs_rd_q;
		val_wd = val_q;
		nxt_we = 1'b0;
		nxt_wa = ix_q[NW-1:0];
		nxt_wd = NIL;
		prv_we = 1'b0;
		prv_wa = ix_q[NW-1:0];
		prv_wd = NIL;
		fs_we  = 1'b0;
		fs_wa  = init_cnt_q[NW-1:0];
		fs_wd  = init_cnt_q[NW-1:0];
		if (cmd.fs_init) begin
			fs_we = 1'b1;
		end
		if (cmd.link1) begin
			nxt_we = 1'b1;
			nxt_wd = after ? n_q : m_q;
			prv_we = 1'b1;
			prv_wd = after ? m_q : p_q;
		end
		if (cmd.link2) begin
			if (after) begin
				nxt_we = m_ok;
				nxt_wa = m_q[NW-1:0];
				nxt_wd = ix_q;
				prv_we = n_ok;
				prv_wa = n_q[NW-1:0];
				prv_wd = ix_q;
			end else begin
				prv_we = m_ok;
				prv_wa = m_q[NW-1:0];
				prv_wd = ix_q;
				nxt_we = p_ok;
				nxt_wa = p_q[NW-1:0];
				nxt_wd = ix_q;
			end
		end
		if (cmd.drop) begin
			nxt_we = p_ok;
			nxt_wa = p_q[NW-1:0];
			nxt_wd = n_q;
			prv_we = n_ok;
			prv_wa = n_q[NW-1:0];
			prv_wd = p_q;
			fs_we  = free_top_q < NIL;
			fs_wa  = free_top_q[NW-1:0];
			fs_wd  = m_q[NW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa] <= val_wd;
		if (cmd.node_rd) rd_val_q <= val_mem[sel_ix[NW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (cmd.node_rd) rd_nxt_q <= nxt_mem[sel_ix[NW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (cmd.node_rd) rd_prv_q <= prv_mem[sel_ix[NW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[fs_wa] <= fs_wd;
		if (cmd.alloc_rd) fs_rd_q <= fs_mem[ftm1[NW-1:0]];
	end

	// Working registers of one transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_op;
			key_q       <= in_key;
			val_q       <= in_value;
			res_stat_q  <= RS_DONE;
			res_found_q <= 1'b0;
			rem_v_q     <= 1'b0;
			rem_val_q   <= 32'd0;
		end
		if (cmd.set_status) res_stat_q <= cmd.status;
		if (cmd.set_found) res_found_q <= 1'b1;
		if (cmd.walk_init) begin
			cur_q   <= sel_ix;
			steps_q <= '0;
		end
		if (cmd.walk_adv) begin
			cur_q   <= rd_nxt_q;
			steps_q <= steps_q + IW'(1);
		end
		if (cmd.capture) begin
			m_q       <= cur_q;
			p_q       <= rd_prv_q;
			n_q       <= rd_nxt_q;
			cap_val_q <= rd_val_q;
		end
		if (cmd.push_setup) begin
			p_q <= NIL;
			n_q <= NIL;
			if (sts.empty) m_q <= NIL;
			else if (op_q == OP_PUSH_FRONT) m_q <= head_q;
			else m_q <= tail_q;
		end
		if (cmd.take) ix_q <= IW'(fs_rd_q);
		if (cmd.drop) begin
			rem_v_q   <= 1'b1;
			rem_val_q <= cap_val_q;
		end
	end

	// List ends, free stack top and the clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= NIL;
			tail_q     <= NIL;
			free_top_q <= NIL;
			init_cnt_q <= '0;
		end else begin
			if (cmd.fs_init) init_cnt_q <= init_cnt_q + IW'(1);
			if (cmd.take) free_top_q <= ftm1;
			if (cmd.link2) begin
				if (!m_ok) begin
					head_q <= ix_q;
					tail_q <= ix_q;
				end else if (after && !n_ok) begin
					tail_q <= ix_q;
				end else if (!after && !p_ok) begin
					head_q <= ix_q;
				end
			end
			if (cmd.drop) begin
				if (!p_ok) head_q <= n_q;
				if (!n_ok) tail_q <= p_q;
				if (free_top_q < NIL) free_top_q <= free_top_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status    <= res_stat_q;
			out_found     <= res_found_q;
			out_rem_valid <= rem_v_q;
			out_rem_value <= rem_val_q;
		end
	end

	always_comb begin
		sts.init_done = init_cnt_q == NIL;
		sts.full      = free_top_q == '0;
		sts.head_nil  = !(head_q < NIL);
		sts.tail_nil  = !(tail_q < NIL);
		sts.empty     = sts.head_nil || sts.tail_nil;
		sts.op        = op_t'(op_q);
		sts.match     = rd_val_q == key_q;
		sts.walk_end  = !(rd_nxt_q < NIL) || (steps_q == IW'(CAPACITY - 1));
		sts.out_free  = !out_valid || out_ready;
	end

endmodule

`default_nettype wire

### design/dll_ctrl.sv
// ---------------------------------------------------------------------------
// dll_ctrl: sequencer of the doubly linked list engine
// Steps each operation through allocation, list walk, linking and removal.
// ---------------------------------------------------------------------------
`default_nettype none

module dll_ctrl import dll_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: if (sts.init_done) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (sts.op) inside
					OP_PUSH_FRONT, OP_PUSH_BACK: state_d = sts.full ? S_FIN : S_TAKE;
					OP_POP_FRONT, OP_POP_BACK: state_d = sts.empty ? S_FIN : S_CAPT;
					default: state_d = sts.empty ? S_FIN : S_WALK;
				endcase
			end
			S_CAPT: state_d = S_DROP;
			S_WALK: begin
				if (sts.match) begin
					case (sts.op) inside
						OP_DELETE: state_d = S_DROP;
						OP_INS_AFTER, OP_INS_BEFORE: state_d = sts.full ? S_FIN : S_TAKE;
						default: state_d = S_FIN;
					endcase
				end else if (sts.walk_end) begin
					state_d = S_FIN;
				end
			end
			S_DROP:  state_d = S_FIN;
			S_TAKE:  state_d = S_LINK1;
			S_LINK1: state_d = S_LINK2;
			S_LINK2: state_d = S_FIN;
			S_FIN:   if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: cmd.fs_init = !sts.init_done;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DISPATCH: begin
				case (sts.op) inside
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = RS_FULL;
						end else begin
							cmd.alloc_rd   = 1'b1;
							cmd.push_setup = 1'b1;
						end
					end
					default: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = RS_EMPTY;
						end else begin
							cmd.node_rd   = 1'b1;
							cmd.walk_init = 1'b1;
							cmd.rd_sel    = (sts.op == OP_POP_BACK) ? RA_TAIL : RA_HEAD;
						end
					end
				endcase
			end
			S_CAPT: cmd.capture = 1'b1;
			S_WALK: begin
				if (sts.match) begin
					cmd.capture   = 1'b1;
					cmd.set_found = 1'b1;
					if ((sts.op == OP_INS_AFTER || sts.op == OP_INS_BEFORE)) begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = RS_FULL;
						end else begin
							cmd.alloc_rd = 1'b1;
						end
					end
				end else if (sts.walk_end) begin
					cmd.set_status = 1'b1;
					cmd.status     = RS_NOT_FOUND;
				end else begin
					cmd.node_rd  = 1'b1;
					cmd.rd_sel   = RA_NEXT;
					cmd.walk_adv = 1'b1;
				end
			end
			S_DROP:  cmd.drop  = 1'b1;
			S_TAKE:  cmd.take  = 1'b1;
			S_LINK1: cmd.link1 = 1'b1;
			S_LINK2: cmd.link2 = 1'b1;
			S_FIN:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/doubly_linked_list_engine.sv
// ---------------------------------------------------------------------------
// doubly_linked_list_engine: doubly linked list of signed 32-bit values
// A sequencer and a datapath keep a list in a node store of CAPACITY
// entries with a free stack, and answer one result per operation.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bits first)
//  s_*       in         operation[2:0], key[34:3], value[66:35]
//  m_*       out        status[1:0], found[2], removed_valid[3],
//                       removed_value[35:4]
//
// A push goes from acceptance through dispatch, node take and linking to the
// result; a pop through dispatch, capture and removal. Search, insert at a match and
// delete walk one node per cycle through the registered read port, then an insert
// takes a node and links it in and a delete unlinks the match. After reset a
// clearing pass fills the free stack; no transaction is accepted until it ends. A
// finished result waits in the output register while the next one is worked on.
//
`default_nettype none

module doubly_linked_list_engine import dll_pkg::*; #(
	parameter int CAPACITY = CAP_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // operation, key, value, zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // status, found, removed_valid, removed_value, zero fill
);

	cmd_t        cmd;
	sts_t        sts;
	logic [1:0]  out_status;
	logic        out_found, out_rem_valid;
	logic [31:0] out_rem_value;

	// The sequencer owns the handshake on the input side.
	dll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the list and the output register.
	dll_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_op         (s_tdata[2:0]),
		.in_key        (s_tdata[34:3]),
		.in_value      (s_tdata[66:35]),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_status    (out_status),
		.out_found     (out_found),
		.out_rem_valid (out_rem_valid),
		.out_rem_value (out_rem_value)
	);

	assign m_tdata = {4'd0, out_rem_value, out_rem_valid, out_found, out_status};

	// A node is never taken from an empty free stack.
	a_no_alloc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !sts.full) else $error("allocation from a full store");

	// The result register is loaded only when its slot is free.
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");

	// Head and tail are null together.
	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		sts.head_nil == sts.tail_nil) else $error("list ends disagree");

	// No transaction is accepted during the clearing pass.
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> sts.init_done) else $error("accepted before free stack filled");

endmodule

`default_nettype wire

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: stream-level test of the doubly linked list engine
// Drives list operations into the slave stream, predicts each result with
// a private copy of the list, and compares every master-stream transaction
// against the oldest prediction under changing idle and stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

import dll_pkg::*;

typedef struct packed {
	logic [31:0] removed_value;
	logic        removed_valid;
	logic        found;
	rstat_t      status;
} list_result_t;

// Holds the predicted list and the queue of results still owed by the block.
class list_scoreboard;
	localparam int CAP = CAP_DEFAULT;
	localparam int NIL = CAP_DEFAULT;
	logic [31:0] val_mem[CAP];
	int next_ix[CAP];
	int prev_ix[CAP];
	int free_ix[CAP];
	int free_cnt;
	int head;
	int tail;
	list_result_t pending[$];
	int errors;

	function new();
		for (int i = 0; i < CAP; i++) begin
			free_ix[i] = i;
			val_mem[i] = '0;
			next_ix[i] = NIL;
			prev_ix[i] = NIL;
		end
		free_cnt = CAP;
		head = NIL;
		tail = NIL;
		errors = 0;
	endfunction

	function int list_len();
		return CAP - free_cnt;
	endfunction

	function int take_node(logic [31:0] v);
		int ix;
		free_cnt--;
		ix = free_ix[free_cnt];
		val_mem[ix] = v;
		return ix;
	endfunction

	function void unlink(int ix);
		int p;
		int n;
		p = prev_ix[ix];
		n = next_ix[ix];
		if (p < NIL) next_ix[p] = n; else head = n;
		if (n < NIL) prev_ix[n] = p; else tail = p;
		free_ix[free_cnt] = ix;
		free_cnt++;
	endfunction

	function int find_first(logic [31:0] k);
		int cur;
		cur = head;
		for (int s = 0; s < CAP && cur < NIL; s++) begin
			if (val_mem[cur] == k) return cur;
			cur = next_ix[cur];
		end
		return NIL;
	endfunction

	// Pick an existing element value, so that keys hit often.
	function logic [31:0] some_value();
		int cur;
		int n;
		cur = head;
		n = $urandom_range(list_len() - 1, 0);
		for (int s = 0; s < n; s++) cur = next_ix[cur];
		return val_mem[cur];
	endfunction

	// Applies one accepted operation and queues the result it must give.
	function void note_input(op_t op, logic [31:0] key, logic [31:0] value);
		list_result_t r;
		int ix;
		int m;
		int nb;
		r = '0;
		r.status = RS_DONE;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
			if (free_cnt == 0) begin
				r.status = RS_FULL;
			end else begin
				ix = take_node(value);
				if (head == NIL) begin
					next_ix[ix] = NIL;
					prev_ix[ix] = NIL;
					head = ix;
					tail = ix;
				end else if (op == OP_PUSH_FRONT) begin
					prev_ix[ix] = NIL;
					next_ix[ix] = head;
					prev_ix[head] = ix;
					head = ix;
				end else begin
					next_ix[ix] = NIL;
					prev_ix[ix] = tail;
					next_ix[tail] = ix;
					tail = ix;
				end
			end
		end else if (head == NIL) begin
			r.status = RS_EMPTY;
		end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
			ix = (op == OP_POP_FRONT) ? head : tail;
			r.removed_valid = 1'b1;
			r.removed_value = val_mem[ix];
			unlink(ix);
		end else begin
			m = find_first(key);
			if (m == NIL) begin
				r.status = RS_NOT_FOUND;
			end else begin
				r.found = 1'b1;
				if (op == OP_DELETE) begin
					r.removed_valid = 1'b1;
					r.removed_value = val_mem[m];
					unlink(m);
				end else if (op != OP_SEARCH) begin
					if (free_cnt == 0) begin
						r.status = RS_FULL;
					end else begin
						ix = take_node(value);
						if (op == OP_INS_AFTER) begin
							nb = next_ix[m];
							prev_ix[ix] = m;
							next_ix[ix] = nb;
							if (nb < NIL) prev_ix[nb] = ix; else tail = ix;
							next_ix[m] = ix;
						end else begin
							nb = prev_ix[m];
							next_ix[ix] = m;
							prev_ix[ix] = nb;
							if (nb < NIL) next_ix[nb] = ix; else head = ix;
							prev_ix[m] = ix;
						end
					end
				end
			end
		end
		pending.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	task check_result(logic [39:0] word);
		list_result_t got;
		list_result_t want;
		got = word[35:0];
		if (pending.size() == 0) begin
			report("unexpected result", word[31:0], 0);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) report("status", got.status, want.status);
		if (got.found !== want.found) report("found", got.found, want.found);
		if (got.removed_valid !== want.removed_valid)
			report("removed_valid", got.removed_valid, want.removed_valid);
		if (got.removed_value !== want.removed_value)
			report("removed_value", got.removed_value, want.removed_value);
		if (word[39:36] !== 4'd0) report("fill bits", word[39:36], 0);
	endtask
endclass

module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// Idle percentages for the sender and the receiver, changed per phase.
	int send_idle_pct = 20;
	int recv_stall_pct = 66;

	list_scoreboard sb;

	always #10 clk = ~clk;

	doubly_linked_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // operation, key, value, zero fill
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // status, found, removed_valid, removed_value, zero fill
	);

	// The receiver decides its ready for the next edge at each rising edge,
	// and every accepted result transaction is checked at that same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Sends one operation: optional idle gap, then hold valid until accepted.
	// The prediction is updated at the edge on which the transaction happens.
	task automatic send_op(op_t op, logic [31:0] key, logic [31:0] value);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, value, key, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, key, value);
	endtask

	// Random operation biased toward keys that are present in the list.
	// Push-heavy and pop-heavy stretches let the list swing between empty and full.
	task automatic send_random(int grow);
		op_t op;
		logic [31:0] key;
		logic [31:0] value;
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < grow) op = $urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else if (pick < 60) op = op_t'($urandom_range(4, 2));
		else op = op_t'($urandom_range(7, 5));
		value = $urandom_range(3, 0) == 0 ? $urandom() : $urandom_range(15, 0);
		if (sb.list_len() > 0 && $urandom_range(3, 0) != 0) key = sb.some_value();
		else key = $urandom_range(1, 0) ? $urandom() : $urandom_range(15, 0);
		send_op(op, key, value);
	endtask

	initial begin
		int phase_pct[3][2];
		sb = new();
		phase_pct = '{'{20, 66}, '{66, 20}, '{0, 0}};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list answers, extremes, both ends and every match case.
		send_op(OP_SEARCH, 32'h0, 32'h0);
		send_op(OP_INS_AFTER, 32'h0, 32'h1);
		send_op(OP_INS_BEFORE, 32'h0, 32'h1);
		send_op(OP_POP_FRONT, 32'h0, 32'h0);
		send_op(OP_POP_BACK, 32'h0, 32'h0);
		send_op(OP_DELETE, 32'h0, 32'h0);
		send_op(OP_PUSH_BACK, 32'h0, 32'h8000_0000);
		send_op(OP_DELETE, 32'h8000_0000, 32'h0);
		send_op(OP_PUSH_FRONT, 32'h0, 32'h7FFF_FFFF);
		send_op(OP_PUSH_BACK, 32'h0, 32'hFFFF_FFFF);
		send_op(OP_INS_AFTER, 32'hFFFF_FFFF, 32'h5);
		send_op(OP_INS_BEFORE, 32'h7FFF_FFFF, 32'h5);
		send_op(OP_SEARCH, 32'h5, 32'h0);
		send_op(OP_SEARCH, 32'h1234_5678, 32'h0);
		send_op(OP_DELETE, 32'h1234_5678, 32'h0);
		send_op(OP_INS_AFTER, 32'h1234_5678, 32'h0);
		send_op(OP_DELETE, 32'h5, 32'h0);
		send_op(OP_POP_BACK, 32'h0, 32'h0);
		send_op(OP_POP_FRONT, 32'h0, 32'h0);
		send_op(OP_POP_FRONT, 32'h0, 32'h0);
		// Fill the store, then hit the full case on pushes and inserts.
		while (sb.list_len() < 64) send_op(OP_PUSH_BACK, 32'h0, $urandom_range(7, 0));
		send_op(OP_PUSH_FRONT, 32'h0, 32'h9);
		send_op(OP_INS_AFTER, sb.some_value(), 32'h9);
		send_op(OP_INS_BEFORE, 32'h0BAD_0000, 32'h9);
		send_op(OP_SEARCH, sb.val_mem[sb.tail], 32'h0);
		while (sb.list_len() > 0) send_op(OP_DELETE, sb.some_value(), 32'h0);

		// Random part in three idling phases; growth bias cycles in stretches.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = phase_pct[ph][0];
			recv_stall_pct = phase_pct[ph][1];
			for (int n = 0; n < 433; n++) send_random(((n / 80) % 2) ? 10 : 45);
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	// Worst case per item: a walk of the whole list plus sender and receiver stalls.
	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
